// ===== rtl/rpfa_pkg.sv =====
package rpfa_pkg;

  localparam int DEF_MAX_PAGES  = 32768;
  localparam int DEF_COUNT_BITS = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam int CMD_W       = 3;
  localparam int PAGE_W      = 15;
  localparam int COUNT_OUT_W = 16;
  localparam int STATUS_W    = 3;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INC   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEC   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OOM       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FRAME = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [PAGE_W-1:0] page_index;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [PAGE_W-1:0]      frame_out;
    logic [COUNT_OUT_W-1:0] count_out;
    logic                   returned_to_pool;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_FREE,
    OP_INC,
    OP_DEC,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              bad;
    logic [PAGE_W-1:0] idx;
  } job_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } bk_state_t;

endpackage

// ===== rtl/rpfa_ram.sv =====
module rpfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

  assign rdata = rd_data_r;

endmodule

// ===== rtl/rpfa_front.sv =====
module rpfa_front #(
  parameter int MAX_PAGES = rpfa_pkg::DEF_MAX_PAGES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rpfa_pkg::in_item_t in_data,
  input  logic               clearing,
  output logic               push,
  output rpfa_pkg::job_t     push_job,
  input  logic               q_full
);

  logic           hold_valid_r;
  logic           hold_valid_nxt;
  rpfa_pkg::job_t hold_job_r;
  rpfa_pkg::job_t hold_job_nxt;
  rpfa_pkg::job_t dec_job;
  logic           accept;

  always_comb begin
    dec_job.idx = in_data.page_index;
    unique case (in_data.cmd)
      rpfa_pkg::CMD_ALLOC: dec_job.op = rpfa_pkg::OP_ALLOC;
      rpfa_pkg::CMD_FREE:  dec_job.op = rpfa_pkg::OP_FREE;
      rpfa_pkg::CMD_INC:   dec_job.op = rpfa_pkg::OP_INC;
      rpfa_pkg::CMD_DEC:   dec_job.op = rpfa_pkg::OP_DEC;
      rpfa_pkg::CMD_READ:  dec_job.op = rpfa_pkg::OP_READ;
      default:             dec_job.op = rpfa_pkg::OP_READ;
    endcase
    dec_job.bad = (in_data.cmd != rpfa_pkg::CMD_ALLOC) &&
                  (32'(in_data.page_index) >= 32'(MAX_PAGES));
  end

  assign in_stall = clearing || (hold_valid_r && q_full);
  assign accept   = in_valid && !in_stall;
  assign push     = hold_valid_r && !q_full;
  assign push_job = hold_job_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_job_nxt   = hold_job_r;
    if (push) begin
      hold_valid_nxt = 1'b0;
    end
    if (accept) begin
      hold_valid_nxt = 1'b1;
      hold_job_nxt   = dec_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
    hold_job_r <= hold_job_nxt;
  end

endmodule

// ===== rtl/rpfa_queue.sv =====
module rpfa_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rpfa_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output rpfa_pkg::job_t pop_job
);

  localparam int PTR_W = $clog2(rpfa_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(rpfa_pkg::QUEUE_DEPTH + 1);

  rpfa_pkg::job_t   slot_r [rpfa_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign full    = (cnt_r == CNT_W'(rpfa_pkg::QUEUE_DEPTH));
  assign valid   = (cnt_r != '0);
  assign pop_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(rpfa_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(rpfa_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/rpfa_back.sv =====
module rpfa_back #(
  parameter int MAX_PAGES  = rpfa_pkg::DEF_MAX_PAGES,
  parameter int COUNT_BITS = rpfa_pkg::DEF_COUNT_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  rpfa_pkg::job_t      q_job,
  output logic                pop,
  output logic                clearing,
  output logic                out_valid,
  input  logic                out_stall,
  output rpfa_pkg::out_item_t out_data
);

  localparam int FRAME_W = $clog2(MAX_PAGES);
  localparam int FILL_W  = $clog2(MAX_PAGES + 1);

  rpfa_pkg::bk_state_t state_r;
  rpfa_pkg::bk_state_t state_nxt;
  logic [FRAME_W-1:0]  clr_addr_r;
  logic [FRAME_W-1:0]  clr_addr_nxt;
  logic [FILL_W-1:0]   fill_r;
  logic [FILL_W-1:0]   fill_nxt;
  logic [FILL_W-1:0]   mark_r;
  logic [FILL_W-1:0]   mark_nxt;
  rpfa_pkg::job_t      cur_r;
  rpfa_pkg::job_t      cur_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  rpfa_pkg::out_item_t out_r;
  rpfa_pkg::out_item_t out_nxt;

  logic                  ref_we;
  logic [FRAME_W-1:0]    ref_waddr;
  logic [COUNT_BITS-1:0] ref_wdata;
  logic [FRAME_W-1:0]    ref_raddr;
  logic [COUNT_BITS-1:0] cnt;
  logic                  stk_we;
  logic [FRAME_W-1:0]    stk_waddr;
  logic [FRAME_W-1:0]    stk_raddr;
  logic [FRAME_W-1:0]    stk_rdata;
  logic [FRAME_W-1:0]    idx_f;
  logic [FRAME_W-1:0]    frame;

  rpfa_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (MAX_PAGES)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (ref_waddr),
    .wdata (ref_wdata),
    .raddr (ref_raddr),
    .rdata (cnt)
  );

  rpfa_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (MAX_PAGES)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (idx_f),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign ref_raddr = FRAME_W'(q_job.idx);
  assign stk_raddr = FRAME_W'(fill_r - FILL_W'(1));
  assign stk_waddr = FRAME_W'(fill_r);
  assign idx_f     = FRAME_W'(cur_r.idx);
  assign clearing  = (state_r == rpfa_pkg::BK_CLEAR);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    fill_nxt      = fill_r;
    mark_nxt      = mark_r;
    cur_nxt       = cur_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    pop           = 1'b0;
    ref_we        = 1'b0;
    ref_waddr     = idx_f;
    ref_wdata     = '0;
    stk_we        = 1'b0;
    frame         = '0;
    unique case (state_r)
      rpfa_pkg::BK_CLEAR: begin
        ref_we    = 1'b1;
        ref_waddr = clr_addr_r;
        if (clr_addr_r == FRAME_W'(MAX_PAGES - 1)) begin
          state_nxt = rpfa_pkg::BK_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      rpfa_pkg::BK_IDLE: begin
        if (q_valid && (!out_valid_r || !out_stall)) begin
          pop       = 1'b1;
          cur_nxt   = q_job;
          state_nxt = rpfa_pkg::BK_EXEC;
        end
      end
      rpfa_pkg::BK_EXEC: begin
        state_nxt                = rpfa_pkg::BK_IDLE;
        out_valid_nxt            = 1'b1;
        out_nxt.status           = rpfa_pkg::ST_OK;
        out_nxt.frame_out        = cur_r.idx;
        out_nxt.count_out        = '0;
        out_nxt.returned_to_pool = 1'b0;
        if (cur_r.bad) begin
          out_nxt.status = rpfa_pkg::ST_BAD_FRAME;
        end else begin
          case (cur_r.op)
            rpfa_pkg::OP_ALLOC: begin
              if (fill_r != '0) begin
                fill_nxt = fill_r - FILL_W'(1);
                frame    = stk_rdata;
              end else if (mark_r != '0) begin
                mark_nxt = mark_r - FILL_W'(1);
                frame    = FRAME_W'(mark_r - FILL_W'(1));
              end
              if (fill_r == '0 && mark_r == '0) begin
                out_nxt.status    = rpfa_pkg::ST_OOM;
                out_nxt.frame_out = '0;
              end else begin
                ref_we            = 1'b1;
                ref_waddr         = frame;
                ref_wdata         = COUNT_BITS'(1);
                out_nxt.frame_out = rpfa_pkg::PAGE_W'(frame);
                out_nxt.count_out = rpfa_pkg::COUNT_OUT_W'(1);
              end
            end
            rpfa_pkg::OP_FREE: begin
              ref_we = 1'b1;
              if (cnt > COUNT_BITS'(1)) begin
                ref_wdata         = cnt - COUNT_BITS'(1);
                out_nxt.count_out = rpfa_pkg::COUNT_OUT_W'(cnt - COUNT_BITS'(1));
              end else if (fill_r == FILL_W'(MAX_PAGES)) begin
                out_nxt.status = rpfa_pkg::ST_OVERFLOW;
              end else begin
                stk_we                   = 1'b1;
                fill_nxt                 = fill_r + FILL_W'(1);
                out_nxt.returned_to_pool = 1'b1;
              end
            end
            rpfa_pkg::OP_INC: begin
              if (&cnt) begin
                out_nxt.status    = rpfa_pkg::ST_SATURATED;
                out_nxt.count_out = rpfa_pkg::COUNT_OUT_W'(cnt);
              end else begin
                ref_we            = 1'b1;
                ref_wdata         = cnt + COUNT_BITS'(1);
                out_nxt.count_out = rpfa_pkg::COUNT_OUT_W'(cnt + COUNT_BITS'(1));
              end
            end
            rpfa_pkg::OP_DEC: begin
              if (cnt == '0) begin
                out_nxt.status = rpfa_pkg::ST_SATURATED;
              end else begin
                ref_we            = 1'b1;
                ref_wdata         = cnt - COUNT_BITS'(1);
                out_nxt.count_out = rpfa_pkg::COUNT_OUT_W'(cnt - COUNT_BITS'(1));
              end
            end
            default: begin
              out_nxt.count_out = rpfa_pkg::COUNT_OUT_W'(cnt);
            end
          endcase
        end
      end
      default: begin
        state_nxt = rpfa_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpfa_pkg::BK_CLEAR;
      clr_addr_r  <= '0;
      fill_r      <= '0;
      mark_r      <= FILL_W'(MAX_PAGES);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      fill_r      <= fill_nxt;
      mark_r      <= mark_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

endmodule

// ===== rtl/refcounted_page_frame_allocator_core.sv =====
// Channel   Ports                            Word
// command   in_valid, in_stall, in_data      cmd, page_index
// result    out_valid, out_stall, out_data   status, frame_out, count_out, returned_to_pool
//
// The execute stage reads the count and stack memories when it takes a command from the queue,
// then writes them back and registers the result before it takes the next command.
// A command passes an input register and a two-word queue before execution.
// After reset the count memory is cleared, address by address, while in_stall is high.
// A stalled result holds in the output register while three more commands can wait
// upstream, one in the input register and two in the queue.
module refcounted_page_frame_allocator_core #(
  parameter int MAX_PAGES  = rpfa_pkg::DEF_MAX_PAGES,
  parameter int COUNT_BITS = rpfa_pkg::DEF_COUNT_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rpfa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rpfa_pkg::out_item_t out_data
);

  logic           clearing;
  logic           push;
  rpfa_pkg::job_t push_job;
  logic           q_full;
  logic           q_valid;
  logic           pop;
  rpfa_pkg::job_t q_job;

  rpfa_front #(
    .MAX_PAGES (MAX_PAGES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .clearing (clearing),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  rpfa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .pop_job  (q_job)
  );

  rpfa_back #(
    .MAX_PAGES  (MAX_PAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_valid)
    else $error("result issued during count memory clear");

  a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid && !clearing)
    else $error("queue popped while empty or clearing");

  a_returned_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.returned_to_pool |->
      out_data.count_out == '0 && out_data.status == rpfa_pkg::ST_OK)
    else $error("frame returned to pool with nonzero count");

  a_oom_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == rpfa_pkg::ST_OOM |->
      out_data.frame_out == '0 && out_data.count_out == '0)
    else $error("out of memory result carries a frame");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int PAGES = rpfa_pkg::DEF_MAX_PAGES;
  localparam int COUNT_W = rpfa_pkg::DEF_COUNT_BITS;
  localparam logic [COUNT_W-1:0] COUNT_TOP = '1;
  localparam int WATCHDOG_LIMIT = 4 * PAGES + 10000;
  localparam logic [rpfa_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [rpfa_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [rpfa_pkg::CMD_W-1:0] CMD_SPARE_C = 3'd7;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  rpfa_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  rpfa_pkg::out_item_t out_data;

  logic [COUNT_W-1:0] count_table [PAGES];
  logic [rpfa_pkg::PAGE_W-1:0] free_stack_mem [PAGES];
  int stack_depth;
  int fresh_mark;

  rpfa_pkg::out_item_t expected_results [$];
  logic [rpfa_pkg::PAGE_W-1:0] held_frames [$];
  rpfa_pkg::out_item_t want;
  int error_count;
  int burst_left;
  int idle_cycles;
  logic [15:0] stall_pattern;
  int pattern_age;

  refcounted_page_frame_allocator_core #(
    .MAX_PAGES(PAGES),
    .COUNT_BITS(COUNT_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic rpfa_pkg::out_item_t predict_result(
      logic [rpfa_pkg::CMD_W-1:0] op_code, logic [rpfa_pkg::PAGE_W-1:0] frame_idx);
    rpfa_pkg::out_item_t r;
    logic [COUNT_W-1:0] c;
    int frame;
    r = '0;
    if (op_code == rpfa_pkg::CMD_ALLOC) begin
      if (stack_depth > 0) begin
        stack_depth--;
        frame = free_stack_mem[stack_depth];
      end else if (fresh_mark > 0) begin
        fresh_mark--;
        frame = fresh_mark;
      end else begin
        r.status = rpfa_pkg::ST_OOM;
        return r;
      end
      count_table[frame] = COUNT_W'(1);
      r.frame_out = rpfa_pkg::PAGE_W'(frame);
      r.count_out = rpfa_pkg::COUNT_OUT_W'(1);
      return r;
    end
    r.frame_out = frame_idx;
    if (int'(frame_idx) >= PAGES) begin
      r.status = rpfa_pkg::ST_BAD_FRAME;
      return r;
    end
    c = count_table[frame_idx];
    case (op_code)
      rpfa_pkg::CMD_FREE: begin
        if (c > COUNT_W'(1)) begin
          count_table[frame_idx] = c - COUNT_W'(1);
          r.count_out = rpfa_pkg::COUNT_OUT_W'(c - COUNT_W'(1));
        end else begin
          count_table[frame_idx] = '0;
          if (stack_depth >= PAGES) begin
            r.status = rpfa_pkg::ST_OVERFLOW;
          end else begin
            free_stack_mem[stack_depth] = frame_idx;
            stack_depth++;
            r.returned_to_pool = 1'b1;
          end
        end
      end
      rpfa_pkg::CMD_INC: begin
        if (c == COUNT_TOP) begin
          r.status = rpfa_pkg::ST_SATURATED;
          r.count_out = rpfa_pkg::COUNT_OUT_W'(c);
        end else begin
          count_table[frame_idx] = c + COUNT_W'(1);
          r.count_out = rpfa_pkg::COUNT_OUT_W'(c + COUNT_W'(1));
        end
      end
      rpfa_pkg::CMD_DEC: begin
        if (c == '0) begin
          r.status = rpfa_pkg::ST_SATURATED;
        end else begin
          count_table[frame_idx] = c - COUNT_W'(1);
          r.count_out = rpfa_pkg::COUNT_OUT_W'(c - COUNT_W'(1));
        end
      end
      default: begin
        r.count_out = rpfa_pkg::COUNT_OUT_W'(c);
      end
    endcase
    return r;
  endfunction

  task automatic send_word(input logic [rpfa_pkg::CMD_W-1:0] op_code,
                           input logic [rpfa_pkg::PAGE_W-1:0] frame_idx,
                           output rpfa_pkg::out_item_t predicted);
    rpfa_pkg::in_item_t w;
    int gap;
    w.cmd = op_code;
    w.page_index = frame_idx;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_result(op_code, frame_idx);
    expected_results.push_back(predicted);
    if (op_code == rpfa_pkg::CMD_ALLOC && predicted.status == rpfa_pkg::ST_OK) begin
      held_frames.push_back(predicted.frame_out);
      if (held_frames.size() > 48) void'(held_frames.pop_front());
    end
  endtask

  task automatic test_directed();
    rpfa_pkg::out_item_t got;
    send_word(rpfa_pkg::CMD_ALLOC, '1, got);
    send_word(rpfa_pkg::CMD_ALLOC, '0, got);
    send_word(rpfa_pkg::CMD_ALLOC, 15'h2AAA, got);
    send_word(rpfa_pkg::CMD_READ, 15'h7FFF, got);
    send_word(rpfa_pkg::CMD_INC, 15'h7FFF, got);
    send_word(rpfa_pkg::CMD_INC, 15'h7FFF, got);
    send_word(rpfa_pkg::CMD_FREE, 15'h7FFF, got);
    send_word(rpfa_pkg::CMD_DEC, 15'h7FFF, got);
    send_word(rpfa_pkg::CMD_FREE, 15'h7FFF, got);
    send_word(rpfa_pkg::CMD_ALLOC, 15'h1234, got);
    send_word(rpfa_pkg::CMD_DEC, 15'h7FFE, got);
    send_word(rpfa_pkg::CMD_DEC, 15'h7FFE, got);
    send_word(rpfa_pkg::CMD_FREE, 15'h7FFE, got);
    // A frame freed twice is pushed twice and comes back from two allocations.
    send_word(rpfa_pkg::CMD_FREE, 15'h0000, got);
    send_word(rpfa_pkg::CMD_FREE, 15'h0000, got);
    send_word(rpfa_pkg::CMD_INC, 15'h0000, got);
    send_word(rpfa_pkg::CMD_READ, 15'h0000, got);
    send_word(CMD_SPARE_A, 15'h0000, got);
    send_word(CMD_SPARE_B, 15'h7FFF, got);
    send_word(CMD_SPARE_C, 15'h5555, got);
    send_word(rpfa_pkg::CMD_ALLOC, 15'h7FFF, got);
    send_word(rpfa_pkg::CMD_ALLOC, 15'h0000, got);
    send_word(rpfa_pkg::CMD_ALLOC, 15'h5555, got);
    send_word(rpfa_pkg::CMD_READ, 15'h7FFD, got);
  endtask

  task automatic test_count_floor();
    rpfa_pkg::out_item_t got;
    logic [rpfa_pkg::PAGE_W-1:0] frame;
    int steps;
    frame = 15'h2AAA;
    steps = int'(count_table[frame]);
    repeat (steps) send_word(rpfa_pkg::CMD_DEC, frame, got);
    send_word(rpfa_pkg::CMD_DEC, frame, got);
    send_word(rpfa_pkg::CMD_DEC, frame, got);
    send_word(rpfa_pkg::CMD_READ, frame, got);
    send_word(rpfa_pkg::CMD_INC, frame, got);
    send_word(rpfa_pkg::CMD_FREE, frame, got);
    send_word(rpfa_pkg::CMD_FREE, frame, got);
    send_word(rpfa_pkg::CMD_READ, frame, got);
  endtask

  task automatic test_random_mix(input int n_words);
    rpfa_pkg::out_item_t got;
    logic [rpfa_pkg::CMD_W-1:0] op_code;
    logic [rpfa_pkg::PAGE_W-1:0] frame_idx;
    int pick;
    repeat (n_words) begin
      pick = $urandom_range(99);
      if (pick < 28) op_code = rpfa_pkg::CMD_ALLOC;
      else if (pick < 50) op_code = rpfa_pkg::CMD_FREE;
      else if (pick < 66) op_code = rpfa_pkg::CMD_INC;
      else if (pick < 78) op_code = rpfa_pkg::CMD_DEC;
      else if (pick < 90) op_code = rpfa_pkg::CMD_READ;
      else op_code = rpfa_pkg::CMD_W'($urandom_range(int'(CMD_SPARE_C), int'(CMD_SPARE_A)));
      pick = $urandom_range(99);
      if (pick < 65 && held_frames.size() > 0)
        frame_idx = held_frames[$urandom_range(held_frames.size() - 1)];
      else if (pick < 68) frame_idx = '0;
      else if (pick < 71) frame_idx = '1;
      else frame_idx = rpfa_pkg::PAGE_W'($urandom);
      send_word(op_code, frame_idx, got);
    end
  endtask

  task automatic check_field(input string field, input logic [15:0] exp_val,
                             input logic [15:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %0h, actual %0h", field, exp_val, act_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result word %0h arrived with nothing expected", out_data);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 16'(want.status), 16'(out_data.status));
        check_field("frame_out", 16'(want.frame_out), 16'(out_data.frame_out));
        check_field("count_out", want.count_out, out_data.count_out);
        check_field("returned_to_pool", 16'(want.returned_to_pool),
                    16'(out_data.returned_to_pool));
      end
    end
  end

  always @(posedge clk) begin
    if (pattern_age == 0) begin
      pattern_age = $urandom_range(150, 40);
      if ($urandom_range(3) == 0) stall_pattern = '0;
      else stall_pattern = 16'($urandom & $urandom);
    end
    pattern_age--;
    stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    out_stall <= stall_pattern[0];
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    burst_left = 0;
    idle_cycles = 0;
    pattern_age = 0;
    stall_pattern = '0;
    stack_depth = 0;
    fresh_mark = PAGES;
    foreach (count_table[i]) count_table[i] = '0;
    foreach (free_stack_mem[i]) free_stack_mem[i] = '0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_count_floor();
    test_random_mix(910);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
